### src/sfl_pkg.sv
// Shared types and codes for the sorted table floor lookup block.
// No dependencies; imported by every module of the block.
package sfl_pkg;

  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 16;
  localparam int COUNT_W  = 17;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITTEN      = 3'd0,
    ST_EXACT        = 3'd1,
    ST_BETWEEN      = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_EMPTY        = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_SKIP,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_NB_LOW,
    S_NB_HIGH
  } back_state_t;

  function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

### src/sfl_front.sv
// Front stage: accepts input transfers, classifies them into commands and
// holds one command until the queue takes it. Depends on sfl_pkg.
module sfl_front import sfl_pkg::*; #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [SLOT_W-1:0] entry_index,
  input  logic [KEY_W-1:0]  address_value,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd
);

  logic hold_valid;
  logic hold_valid_next;
  cmd_t cmd_in;

  always_comb begin
    cmd_in.slot = entry_index;
    cmd_in.key  = address_value;
    if (operation) begin
      cmd_in.kind = CMD_LOOKUP;
    end else if (32'(entry_index) < 32'(TABLE_DEPTH)) begin
      cmd_in.kind = CMD_WRITE;
    end else begin
      // slot beyond the table: answer, but leave memory alone
      cmd_in.kind = CMD_SKIP;
    end
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_valid && in_ready) begin
      hold_valid_next = 1'b1;
    end else if (push_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      push_cmd <= cmd_in;
    end
  end

endmodule

### src/sfl_queue.sv
// Two-entry command queue between the front and back stages.
// Depends on sfl_pkg for the command type.
module sfl_queue import sfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/sfl_back.sv
// Back stage: holds the address table memory and the entry count, runs the
// binary search one probe at a time and drives the result register. Depends on sfl_pkg.
module sfl_back import sfl_pkg::*; #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   found_index
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  back_state_t      state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] mid, mid_next;
  logic [CNT_W-1:0] mid_c;
  logic [KEY_W-1:0] key, key_next;
  logic             below_ok, below_ok_next;
  logic             out_valid_next;
  status_t          out_status, out_status_next;
  logic [SLOT_W-1:0] out_index, out_index_next;

  assign status      = out_status;
  assign found_index = out_index;
  assign mid_c       = lo + ((hi - lo) >> 1);

  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    key_next        = key;
    below_ok_next   = below_ok;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    rd_addr         = IDX_W'(mid_c);
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_index_next  = out_index;
    case (state)
      S_IDLE: begin
        if (cmd_valid && (!out_valid || out_ready)) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            CMD_WRITE: begin
              mem_we          = 1'b1;
              out_valid_next  = 1'b1;
              out_status_next = ST_WRITTEN;
              out_index_next  = '0;
            end
            CMD_LOOKUP: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
                out_index_next  = '0;
              end else begin
                key_next   = cmd.key;
                lo_next    = '0;
                hi_next    = count;
                state_next = S_PROBE;
              end
            end
            default: begin
              out_valid_next  = 1'b1;
              out_status_next = ST_WRITTEN;
              out_index_next  = '0;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (lo < hi) begin
          rd_addr    = IDX_W'(mid_c);
          mid_next   = mid_c;
          state_next = S_COMPARE;
        end else if (lo != '0 && lo < count) begin
          // search ended inside the table: check both neighbors
          rd_addr    = IDX_W'(lo - 1'b1);
          state_next = S_NB_LOW;
        end else begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OUT_OF_RANGE;
          out_index_next  = '0;
          state_next      = S_IDLE;
        end
      end
      S_COMPARE: begin
        if (key_less(key, rd_data)) begin
          hi_next    = mid;
          state_next = S_PROBE;
        end else if (key_less(rd_data, key)) begin
          lo_next    = mid + 1'b1;
          state_next = S_PROBE;
        end else begin
          out_valid_next  = 1'b1;
          out_status_next = ST_EXACT;
          out_index_next  = SLOT_W'(mid);
          state_next      = S_IDLE;
        end
      end
      S_NB_LOW: begin
        below_ok_next = key_less(rd_data, key);
        rd_addr       = IDX_W'(lo);
        state_next    = S_NB_HIGH;
      end
      S_NB_HIGH: begin
        out_valid_next = 1'b1;
        if (below_ok && key_less(key, rd_data)) begin
          out_status_next = ST_BETWEEN;
          out_index_next  = SLOT_W'(lo - 1'b1);
        end else begin
          out_status_next = ST_OUT_OF_RANGE;
          out_index_next  = '0;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        // saturate the count at the table depth
        if (32'(cfg_wdata) > 32'(TABLE_DEPTH)) begin
          count <= CNT_W'(TABLE_DEPTH);
        end else begin
          count <= CNT_W'(cfg_wdata);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    key        <= key_next;
    below_ok   <= below_ok_next;
    out_status <= out_status_next;
    out_index  <= out_index_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(cmd.slot)] <= cmd.key;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/sorted_table_floor_lookup.sv
// Sorted table floor lookup: a table of signed 64-bit start addresses,
// written in ascending order, searched for the entry at or just below a key
// that lies within the table's range. A write needs no search in the back
// stage, so writes stream at one per clock while results are taken. A
// lookup runs a binary search over the first count entries (set through
// cfg_wdata) on a memory with a registered read: each probe sets the
// address, then compares, and a search that ends inside the table without
// a hit adds a check of the neighbors on both sides. A two-entry queue sits
// between the input stage and the search engine, and results leave through
// an output register, so either side may stall on its own. The table has
// no reset; only written slots may be searched.
module sorted_table_floor_lookup import sfl_pkg::*; #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [SLOT_W-1:0]   entry_index,
  input  logic signed [KEY_W-1:0] address_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   found_index
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  sfl_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .entry_index  (entry_index),
    .address_value(address_value),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  sfl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  sfl_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd        (pop_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_index(found_index)
  );

endmodule

### dv/sorted_table_floor_lookup_tb.sv
// Self-checking testbench for sorted_table_floor_lookup: table writes, floor lookups
// and entry-count settings, checked against an in-bench binary search predictor.
// Depends on sfl_pkg and the sorted_table_floor_lookup RTL.
module sorted_table_floor_lookup_tb;
  import sfl_pkg::*;

  localparam int unsigned TABLE_DEPTH = 65536;
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
  localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    status_t           st;
    logic [SLOT_W-1:0] idx;
  } answer_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [COUNT_W-1:0]      cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic                    operation;
  logic [SLOT_W-1:0]       entry_index;
  logic signed [KEY_W-1:0] address_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_W-1:0]       found_index;

  // predictor state
  logic [KEY_W-1:0] addr_mem [0:TABLE_DEPTH-1];
  int unsigned      count_cfg;
  answer_t          pending_answers[$];

  longint phase_vals[$];
  int     error_count;
  int     hold_req;
  bit     feed_steady;
  bit     sink_steady;

  sorted_table_floor_lookup u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .entry_index   (entry_index),
    .address_value (address_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_index   (found_index)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("** sorted_table_floor_lookup: FAILED **");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // Logs writes; floor search over the first count entries, full 64-bit signed compares.
  function automatic answer_t predict_answer(input logic op, input logic [SLOT_W-1:0] slot,
                                             input logic [KEY_W-1:0] key);
    answer_t          ans;
    int unsigned      n;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    logic [KEY_W-1:0] v;
    bit               hit;
    ans.st  = ST_WRITTEN;
    ans.idx = '0;
    hit     = 1'b0;
    if (op == OP_WRITE) begin
      addr_mem[slot] = key;
      return ans;
    end
    n = (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : count_cfg;
    if (n == 0) begin
      ans.st = ST_EMPTY;
      return ans;
    end
    lo = 0;
    hi = n;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      v   = addr_mem[mid];
      if ($signed(key) < $signed(v)) begin
        hi = mid;
      end else if ($signed(v) < $signed(key)) begin
        lo = mid + 1;
      end else begin
        hit     = 1'b1;
        ans.st  = ST_EXACT;
        ans.idx = SLOT_W'(mid);
      end
    end
    if (!hit) begin
      if (lo >= 1 && lo < n && $signed(addr_mem[lo-1]) < $signed(key) &&
          $signed(key) < $signed(addr_mem[lo])) begin
        ans.st  = ST_BETWEEN;
        ans.idx = SLOT_W'(lo - 1);
      end else begin
        ans.st = ST_OUT_OF_RANGE;
      end
    end
    return ans;
  endfunction

  // Check results first, then log the new input, so a stray result never
  // matches an item accepted on the same edge.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: status %0d index %0d",
                                status, found_index));
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.st) begin
          note_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
        end
        if (found_index !== want.idx) begin
          note_mismatch($sformatf("found_index %0d, want %0d", found_index, want.idx));
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      pending_answers.push_back(predict_answer(operation, entry_index, address_value));
    end
  end

  // Result side: random stall per transfer unless sink_steady, long hold on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      stall = sink_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [KEY_W-1:0] key);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    entry_index   <= slot;
    address_value <= key;
    @(posedge clk iff in_ready);
    @(negedge clk);
  endtask

  task automatic send_write(input int unsigned slot, input logic [KEY_W-1:0] key);
    send_item(OP_WRITE, SLOT_W'(slot), key);
  endtask

  // entry_index is don't-care on lookups, so drive it at random
  task automatic send_lookup(input logic [KEY_W-1:0] key);
    send_item(OP_LOOKUP, SLOT_W'($urandom), key);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_answers.size() != 0);
  endtask

  task automatic set_entries(input int unsigned n);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_wdata <= COUNT_W'(n);
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    count_cfg = n;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Ascending values for a table of n entries, with duplicates and extremes now and then.
  function automatic void build_sorted(input int unsigned n, input bit narrow);
    phase_vals.delete();
    for (int unsigned k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) begin
        phase_vals.push_back(phase_vals[k-1]);
      end else if (narrow) begin
        phase_vals.push_back(longint'($urandom_range(0, 2000)) - 1000);
      end else begin
        phase_vals.push_back(longint'(rand_key()));
      end
    end
    phase_vals.sort();
    if ($urandom_range(0, 3) == 0) phase_vals[0] = longint'(KEY_MIN);
    if ($urandom_range(0, 3) == 0) phase_vals[n-1] = longint'(KEY_MAX);
  endfunction

  // Probe keys aimed at hits, gaps, both ends and random values.
  function automatic logic [KEY_W-1:0] pick_probe_key();
    int unsigned      n;
    int unsigned      i;
    int unsigned      kind;
    logic [KEY_W-1:0] lo_v;
    logic [KEY_W-1:0] hi_v;
    logic [KEY_W-1:0] diff;
    n    = phase_vals.size();
    kind = $urandom_range(0, 9);
    if (kind <= 2 || (kind <= 5 && n < 2)) begin
      return phase_vals[$urandom_range(0, n - 1)];
    end else if (kind <= 5) begin
      i    = $urandom_range(0, n - 2);
      lo_v = phase_vals[i];
      hi_v = phase_vals[i+1];
      diff = hi_v - lo_v;
      if (diff > 1) return lo_v + 1 + (rand_key() % (diff - 1));
      return lo_v;
    end else if (kind == 6) begin
      lo_v = phase_vals[0];
      return (lo_v == KEY_MIN) ? KEY_MIN : lo_v - 1;
    end else if (kind == 7) begin
      hi_v = phase_vals[n-1];
      return (hi_v == KEY_MAX) ? KEY_MAX : hi_v + 1;
    end else if (kind == 8) begin
      return ($urandom_range(0, 1) == 1) ? KEY_MIN : KEY_MAX;
    end
    return rand_key();
  endfunction

  function automatic logic [KEY_W-1:0] full_value(input int unsigned i);
    longint v;
    v = (longint'(i) - 32768) * (longint'(1) << 47) + 12345;
    return v;
  endfunction

  // Slots read by a search over the first n entries of a table that holds
  // full_value(k) in every slot k; only these need writing for this key.
  function automatic void full_path(input logic [KEY_W-1:0] key, input int unsigned n,
                                    ref int unsigned slots[$]);
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    logic [KEY_W-1:0] v;
    bit               hit;
    lo  = 0;
    hi  = n;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      v   = full_value(mid);
      slots.push_back(mid);
      if ($signed(key) < $signed(v)) begin
        hi = mid;
      end else if ($signed(v) < $signed(key)) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
      end
    end
    if (!hit && lo >= 1 && lo < n) begin
      slots.push_back(lo - 1);
      slots.push_back(lo);
    end
  endfunction

  task automatic test_empty_table();
    set_entries(0);
    send_lookup(KEY_MIN);
    send_lookup(KEY_MAX);
    send_lookup('0);
    send_write(0, 64'd5);
  endtask

  task automatic test_directed_entries();
    send_write(0, -(64'sd1 <<< 62));
    send_write(1, -64'sd5);
    send_write(2, 64'sd7);
    send_write(3, 64'sd1 <<< 62);
    set_entries(4);
    for (int i = 0; i < 4; i++) send_lookup(addr_mem[i]);
    send_lookup('0);                        // between entries 1 and 2
    send_lookup(64'sd1 <<< 61);             // between entries 2 and 3
    send_lookup((64'sd1 <<< 62) - 1);       // just under the last entry
    send_lookup(KEY_MIN);                   // below the first entry
    send_lookup(KEY_MAX);                   // above the last entry
    send_item(OP_LOOKUP, '1, 64'sd7);       // index field ignored on lookups
    // extreme entries at both ends
    send_write(0, KEY_MIN);
    send_write(3, KEY_MAX);
    send_lookup(KEY_MIN);
    send_lookup(KEY_MAX);
    send_write(65535, 64'h5A5A_A5A5_0F0F_F0F0);
    // break the order, then restore it
    send_write(1, 64'sd100);
    send_lookup(64'sd50);
    send_lookup(64'sd100);
    send_write(1, -64'sd5);
  endtask

  task automatic test_single_entry();
    set_entries(1);
    send_lookup(addr_mem[0]);
    send_lookup(KEY_MAX);
    send_write(0, 64'sd0);
    send_lookup(-64'sd1);
    send_lookup(64'sd0);
  endtask

  task automatic test_random_tables();
    int unsigned sizes [12] = '{1, 2, 3, 4, 5, 8, 13, 31, 64, 100, 17, 0};
    int unsigned n;
    int unsigned r;
    for (int p = 0; p < 12; p++) begin
      n = (sizes[p] == 0) ? $urandom_range(1, 60) : sizes[p];
      feed_steady = (p % 4 == 1);
      sink_steady = (p % 3 == 2);
      wait_drained();
      build_sorted(n, p % 3 == 0);
      for (int unsigned i = 0; i < n; i++) send_write(i, phase_vals[i]);
      set_entries(n);
      repeat (40) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_write($urandom_range(0, n - 1), rand_key());   // may unsort the table
        end else if (r <= 2) begin
          send_write($urandom_range(n, TABLE_DEPTH - 1), rand_key());
        end else begin
          send_lookup(pick_probe_key());
        end
      end
    end
    feed_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    int unsigned n;
    n = phase_vals.size();
    hold_req    = 300;
    feed_steady = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1) == 1) send_lookup(pick_probe_key());
      else send_write($urandom_range(n, TABLE_DEPTH - 1), rand_key());
    end
    feed_steady = 1'b0;
    wait_drained();
    repeat (20) send_lookup(pick_probe_key());
  endtask

  // Full-depth searches: write only the slots that the chosen keys reach.
  task automatic test_full_table();
    logic [KEY_W-1:0] probes[$];
    logic [KEY_W-1:0] tail_probes[$];
    int unsigned      slots[$];
    bit               filled[int unsigned];
    int unsigned      i;
    probes.push_back(full_value(0));
    probes.push_back(full_value(TABLE_DEPTH - 1));
    probes.push_back(full_value(TABLE_DEPTH - 1) + 1);
    probes.push_back(full_value(0) - 1);
    probes.push_back(KEY_MIN);
    probes.push_back(KEY_MAX);
    repeat (10) begin
      i = $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 2))
        0: probes.push_back(full_value(i));
        1: probes.push_back(full_value(i) + 1 + $urandom);
        default: probes.push_back(rand_key());
      endcase
    end
    // last entry excluded: its own value is above the range
    tail_probes.push_back(full_value(TABLE_DEPTH - 1));
    tail_probes.push_back(full_value(TABLE_DEPTH - 2));
    repeat (3) tail_probes.push_back(full_value($urandom_range(0, TABLE_DEPTH - 1)) + 3);
    foreach (probes[k]) full_path(probes[k], TABLE_DEPTH, slots);
    foreach (tail_probes[k]) full_path(tail_probes[k], TABLE_DEPTH - 1, slots);
    feed_steady = 1'b1;
    sink_steady = 1'b1;
    wait_drained();
    foreach (slots[k]) begin
      if (!filled.exists(slots[k])) begin
        filled[slots[k]] = 1'b1;
        send_write(slots[k], full_value(slots[k]));
      end
    end
    feed_steady = 1'b0;
    sink_steady = 1'b0;
    set_entries(TABLE_DEPTH);
    foreach (probes[k]) send_lookup(probes[k]);
    // count beyond depth saturates
    set_entries(131071);
    foreach (probes[k]) send_lookup(probes[k]);
    set_entries(TABLE_DEPTH - 1);
    foreach (tail_probes[k]) send_lookup(tail_probes[k]);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    operation     = OP_WRITE;
    entry_index   = '0;
    address_value = '0;
    count_cfg     = 0;
    error_count   = 0;
    hold_req      = 0;
    feed_steady   = 1'b0;
    sink_steady   = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed_entries();
    test_single_entry();
    test_random_tables();
    test_backpressure();
    test_full_table();

    wait_drained();
    repeat (64) @(negedge clk);
    if (error_count == 0) begin
      $display("** sorted_table_floor_lookup: PASSED **");
    end else begin
      $display("** sorted_table_floor_lookup: FAILED **");
    end
    $finish;
  end

endmodule
